// ===== hdl/socks5_auth_request_parser_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SOCKS5_AUTH_REQUEST_PARSER_CORE_DEFINES_SVH
`define SOCKS5_AUTH_REQUEST_PARSER_CORE_DEFINES_SVH

// Check a property while out of reset.
`define S5A_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("s5auth assertion failed");

// Check a property at every edge, reset included.
`define S5A_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("s5auth assertion failed");

`endif

// ===== hdl/s5auth_pkg.sv =====
`default_nettype none

package s5auth_pkg;

   localparam logic [7:0] AUTH_VERSION = 8'h01;

   typedef enum logic [2:0] {
      PH_VERSION = 3'd0,
      PH_ULEN    = 3'd1,
      PH_UNAME   = 3'd2,
      PH_PLEN    = 3'd3,
      PH_PASSWD  = 3'd4,
      PH_DONE    = 3'd5,
      PH_BADVER  = 3'd6,
      PH_BADLEN  = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      ROLE_NONE = 2'd0,
      ROLE_USER = 2'd1,
      ROLE_PASS = 2'd2
   } role_type;

   typedef struct packed {
      phase_type  phase;
      logic       failed;
      logic       finished;
      logic       consumed;
      role_type   cred_role;
      logic [7:0] cred_index;
      logic [7:0] cred_byte;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/s5auth_if.sv =====
`default_nettype none

interface s5auth_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       restart;

   modport source (output valid, output data_byte, output restart, input ready);
   modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface s5auth_rsp_if;
   logic                 valid;
   logic                 ready;
   s5auth_pkg::phase_type phase;
   logic                 failed;
   logic                 finished;
   logic                 consumed;
   s5auth_pkg::role_type cred_role;
   logic [7:0]           cred_index;
   logic [7:0]           cred_byte;

   modport source (output valid, output phase, output failed, output finished,
                   output consumed, output cred_role, output cred_index,
                   output cred_byte, input ready);
   modport sink   (input valid, input phase, input failed, input finished,
                   input consumed, input cred_role, input cred_index,
                   input cred_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/socks5_auth_request_parser_core.sv =====
// Username/password authentication request parser.
// req: one byte of the request per transaction (data_byte), with restart to
//    return to the version phase before that byte is handled.
// rsp: exactly one transaction per request byte, in order: phase after the
//    byte, failed, finished, consumed, and for credential bytes the role,
//    index within the username or password, and the byte itself.
// Response: registered; valid in the cycle after the request transaction.
// Throughput: one byte per cycle while rsp is not stalled; the phase and counter update is a compare
//    and an 8-bit increment between the parser state and the response register.
// Reset: synchronous, active high; the parser returns to the version phase
//    with lengths and positions cleared, and no response is pending.
// Stall: while rsp is held off the response register holds its transaction;
//    req.ready stays high as long as the register is empty or drains in the
//    same cycle, so a stalled receiver stops the request side after one byte.
// After finished or an error the parser ignores bytes (consumed low) until
//    a restart.
`default_nettype none

module socks5_auth_request_parser_core (
   input wire logic      clock,
   input wire logic      reset,
   s5auth_req_if.sink    req,
   s5auth_rsp_if.source  rsp
);

   s5auth_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [7:0] ulen_ff, ulen_in, cur_ulen;
   logic [7:0] plen_ff, plen_in, cur_plen;
   logic [7:0] upos_ff, upos_in, cur_upos;
   logic [7:0] ppos_ff, ppos_in, cur_ppos;
   logic       rsp_valid_ff, rsp_valid_in;
   s5auth_pkg::rsp_type rsp_ff, rsp_in;
   logic       accept;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      cur_phase = req.restart ? s5auth_pkg::PH_VERSION : phase_ff;
      cur_ulen  = req.restart ? 8'd0 : ulen_ff;
      cur_plen  = req.restart ? 8'd0 : plen_ff;
      cur_upos  = req.restart ? 8'd0 : upos_ff;
      cur_ppos  = req.restart ? 8'd0 : ppos_ff;

      phase_in = cur_phase;
      ulen_in  = cur_ulen;
      plen_in  = cur_plen;
      upos_in  = cur_upos;
      ppos_in  = cur_ppos;

      rsp_in.cred_role  = s5auth_pkg::ROLE_NONE;
      rsp_in.cred_index = 8'd0;
      rsp_in.cred_byte  = 8'd0;
      rsp_in.consumed   = 1'b1;

      unique case (cur_phase)
         s5auth_pkg::PH_VERSION: begin
            phase_in = (req.data_byte == s5auth_pkg::AUTH_VERSION) ?
                       s5auth_pkg::PH_ULEN : s5auth_pkg::PH_BADVER;
         end
         s5auth_pkg::PH_ULEN: begin
            ulen_in  = req.data_byte;
            phase_in = (req.data_byte == 8'd0) ?
                       s5auth_pkg::PH_BADLEN : s5auth_pkg::PH_UNAME;
         end
         s5auth_pkg::PH_UNAME: begin
            rsp_in.cred_role  = s5auth_pkg::ROLE_USER;
            rsp_in.cred_index = cur_upos;
            rsp_in.cred_byte  = req.data_byte;
            upos_in = cur_upos + 8'd1;
            if (upos_in == cur_ulen) begin
               phase_in = s5auth_pkg::PH_PLEN;
            end
         end
         s5auth_pkg::PH_PLEN: begin
            plen_in  = req.data_byte;
            phase_in = (req.data_byte == 8'd0) ?
                       s5auth_pkg::PH_BADLEN : s5auth_pkg::PH_PASSWD;
         end
         s5auth_pkg::PH_PASSWD: begin
            rsp_in.cred_role  = s5auth_pkg::ROLE_PASS;
            rsp_in.cred_index = cur_ppos;
            rsp_in.cred_byte  = req.data_byte;
            ppos_in = cur_ppos + 8'd1;
            if (ppos_in == cur_plen) begin
               phase_in = s5auth_pkg::PH_DONE;
            end
         end
         s5auth_pkg::PH_DONE, s5auth_pkg::PH_BADVER, s5auth_pkg::PH_BADLEN: begin
            rsp_in.consumed = 1'b0;
         end
      endcase

      rsp_in.phase    = phase_in;
      rsp_in.failed   = (phase_in == s5auth_pkg::PH_BADVER) ||
                        (phase_in == s5auth_pkg::PH_BADLEN);
      rsp_in.finished = (phase_in == s5auth_pkg::PH_DONE) || rsp_in.failed;
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= s5auth_pkg::PH_VERSION;
         ulen_ff      <= 8'd0;
         plen_ff      <= 8'd0;
         upos_ff      <= 8'd0;
         ppos_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            ulen_ff  <= ulen_in;
            plen_ff  <= plen_in;
            upos_ff  <= upos_in;
            ppos_ff  <= ppos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.phase      = rsp_ff.phase;
   assign rsp.failed     = rsp_ff.failed;
   assign rsp.finished   = rsp_ff.finished;
   assign rsp.consumed   = rsp_ff.consumed;
   assign rsp.cred_role  = rsp_ff.cred_role;
   assign rsp.cred_index = rsp_ff.cred_index;
   assign rsp.cred_byte  = rsp_ff.cred_byte;

endmodule

`default_nettype wire

// ===== hdl/s5auth_checker.sv =====
`default_nettype none

`include "socks5_auth_request_parser_core_defines.svh"

module s5auth_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_phase,
   input wire logic       rsp_failed,
   input wire logic       rsp_finished,
   input wire logic       rsp_consumed,
   input wire logic [1:0] rsp_cred_role
);

   `S5A_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid)
   `S5A_ASSERT(a_failed_is_final, rsp_valid && rsp_failed |-> rsp_finished)
   `S5A_ASSERT(a_cred_consumed, rsp_valid && (rsp_cred_role != s5auth_pkg::ROLE_NONE) |-> rsp_consumed && !rsp_failed)
   `S5A_ASSERT(a_stall_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase))

endmodule

bind socks5_auth_request_parser_core s5auth_checker u_s5auth_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_phase     (rsp.phase),
   .rsp_failed    (rsp.failed),
   .rsp_finished  (rsp.finished),
   .rsp_consumed  (rsp.consumed),
   .rsp_cred_role (rsp.cred_role)
);

`default_nettype wire
